### rtl/assert_macros.svh
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Implication checked in the following cycle, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

### rtl/rrts_pkg.sv
// Package with the types and constants of the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

    localparam int MAX_TASKS_DEF    = 16;
    localparam int QUANTUM_BITS_DEF = 16;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_SPAWN       = 3'd1,
        CMD_YIELD       = 3'd2,
        CMD_BLOCK       = 3'd3,
        CMD_WAKE        = 3'd4,
        CMD_EXIT        = 3'd5,
        CMD_PREEMPT_OFF = 3'd6,
        CMD_PREEMPT_ON  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_BLOCKED = 2'd2,
        MODE_DEAD    = 2'd3
    } t_mode;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FREE,
        S_UNLINK,
        S_CHINIT,
        S_CHWALK,
        S_SWITCH,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_EXEC,
        OP_FREE,
        OP_UNLINK,
        OP_CHINIT,
        OP_CHWALK,
        OP_SWITCH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic cur_idle;
        logic tick_switch;
        logic wake_ok;
        logic free_found;
        logic free_last;
        logic unlink_done;
        logic walk_hit;
        logic walk_end;
    } t_sts;

endpackage
`default_nettype wire

### rtl/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler: controller plus datapath.
// Each command runs load, execute, then as needed a free-slot search (spawn), an unlink
// walk (exit), a ring walk (switching tick, yield, block or exit of a task other than
// idle) and a switch (also a switching wake), then the result strobe.
// One command at a time; the ring walks step one slot a cycle, and the receiver cannot
// stall the strobe.
// Reset (synchronous, active low) leaves only the idle task in slot 0, running.
`default_nettype none
module round_robin_task_scheduler_top #(
    parameter int MAX_TASKS    = rrts_pkg::MAX_TASKS_DEF,
    parameter int QUANTUM_BITS = rrts_pkg::QUANTUM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_quantum,
    input  logic [3:0]  i_task_slot,
    output logic        o_valid,
    output logic [3:0]  o_running_slot,
    output logic [31:0] o_running_id,
    output logic        o_switched,
    output logic [31:0] o_new_id,
    output logic [1:0]  o_status
);
    import rrts_pkg::*;

    `include "assert_macros.svh"

    t_ctl ctl;
    t_sts sts;

    // Command sequencer.
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // Slot table and ring state.
    rrts_dpath #(
        .MAX_TASKS    (MAX_TASKS),
        .QUANTUM_BITS (QUANTUM_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_command      (i_command),
        .i_quantum      (i_quantum),
        .i_task_slot    (i_task_slot),
        .o_sts          (sts),
        .o_running_slot (o_running_slot),
        .o_running_id   (o_running_id),
        .o_switched     (o_switched),
        .o_new_id       (o_new_id),
        .o_status       (o_status)
    );

    // A result strobe lasts one cycle and only ends a busy transfer.
    `ASSERT_SAME(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    `ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_valid, o_status != 2'd3)

endmodule
`default_nettype wire

### rtl/rrts_ctrl.sv
// Controller state machine that sequences one scheduler command.
`default_nettype none
module rrts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_ctl o_ctl,
    output logic          busy,
    output logic          o_valid
);
    import rrts_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (i_sts.cmd)
                    CMD_TICK:  n_state = i_sts.tick_switch ? S_CHINIT : S_DONE;
                    CMD_SPAWN: n_state = S_FREE;
                    CMD_YIELD: n_state = S_CHINIT;
                    CMD_BLOCK: n_state = i_sts.cur_idle ? S_DONE : S_CHINIT;
                    CMD_WAKE:  n_state = (i_sts.wake_ok && i_sts.cur_idle) ? S_SWITCH
                                                                             : S_DONE;
                    CMD_EXIT:  n_state = i_sts.cur_idle ? S_DONE : S_UNLINK;
                    default:   n_state = S_DONE;
                endcase
            end
            S_FREE: begin
                if (i_sts.free_found || i_sts.free_last) n_state = S_DONE;
            end
            S_UNLINK: begin
                if (i_sts.unlink_done) n_state = S_CHINIT;
            end
            S_CHINIT: n_state = S_CHWALK;
            S_CHWALK: begin
                if (i_sts.walk_hit || i_sts.walk_end) n_state = S_SWITCH;
            end
            S_SWITCH: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_ctl.op = OP_NONE;
        busy     = 1'b1;
        o_valid  = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) o_ctl.op = OP_LOAD;
            end
            S_EXEC:   o_ctl.op = OP_EXEC;
            S_FREE:   o_ctl.op = OP_FREE;
            S_UNLINK: o_ctl.op = OP_UNLINK;
            S_CHINIT: o_ctl.op = OP_CHINIT;
            S_CHWALK: o_ctl.op = OP_CHWALK;
            S_SWITCH: o_ctl.op = OP_SWITCH;
            S_DONE:   o_valid  = 1'b1;
            default:  o_ctl.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### rtl/rrts_dpath.sv
// Datapath of the scheduler: slot table, ring pointers and walk counter.
`default_nettype none
module rrts_dpath #(
    parameter int MAX_TASKS    = rrts_pkg::MAX_TASKS_DEF,
    parameter int QUANTUM_BITS = rrts_pkg::QUANTUM_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrts_pkg::t_ctl i_ctl,
    input  logic [2:0]     i_command,
    input  logic [15:0]    i_quantum,
    input  logic [3:0]     i_task_slot,
    output rrts_pkg::t_sts o_sts,
    output logic [3:0]     o_running_slot,
    output logic [31:0]    o_running_id,
    output logic           o_switched,
    output logic [31:0]    o_new_id,
    output logic [1:0]     o_status
);
    import rrts_pkg::*;

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = SW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_TASKS - 1);
    localparam logic [SW-1:0] IDLE_SLOT = '0;

    // Slot table.
    logic                    r_used  [MAX_TASKS];
    t_mode                   r_mode  [MAX_TASKS];
    logic [31:0]             r_ident [MAX_TASKS];
    logic [QUANTUM_BITS-1:0] r_quant [MAX_TASKS];
    logic [QUANTUM_BITS-1:0] r_ticks [MAX_TASKS];
    logic [SW-1:0]           r_link  [MAX_TASKS];

    // Command and scheduler registers.
    t_cmd                    r_cmd;
    logic [QUANTUM_BITS-1:0] r_q;
    logic [3:0]              r_ts;
    logic [SW-1:0]           r_cur;
    logic [SW-1:0]           r_head;
    logic [SW-1:0]           r_ptr;
    logic [SW-1:0]           r_nxt;
    logic [SW-1:0]           r_before;
    logic [CW-1:0]           r_cnt;
    logic [31:0]             r_next_id;
    logic [7:0]              r_depth;
    logic [31:0]             r_new_id;
    logic [1:0]              r_status;

    logic [QUANTUM_BITS-1:0] cur_ticks;
    logic [QUANTUM_BITS-1:0] tick_new;
    logic [SW-1:0]           ts_idx;
    logic [SW-1:0]           ptr_link;
    logic [SW-1:0]           cur_link;
    logic [SW-1:0]           head_link;
    logic                    unlink_hit;

    // Status toward the controller.
    always_comb begin
        cur_ticks  = r_ticks[r_cur];
        tick_new   = (cur_ticks == '0) ? '0 : cur_ticks - 1'b1;
        ts_idx     = SW'(r_ts);
        ptr_link   = r_link[r_ptr];
        cur_link   = r_link[r_cur];
        head_link  = r_link[r_head];
        unlink_hit = (ptr_link == r_cur) || (ptr_link == r_head);

        o_sts.cmd         = r_cmd;
        o_sts.cur_idle    = (r_cur == IDLE_SLOT);
        o_sts.tick_switch = (tick_new == '0) && (r_depth == 8'd0);
        o_sts.wake_ok     = (int'(r_ts) < MAX_TASKS) && r_used[ts_idx]
                            && (r_mode[ts_idx] == MODE_BLOCKED);
        o_sts.free_found  = !r_used[r_ptr];
        o_sts.free_last   = (r_ptr == LAST_SLOT);
        o_sts.unlink_done = unlink_hit || (r_cnt == CW'(MAX_TASKS));
        o_sts.walk_hit    = (r_mode[r_ptr] == MODE_READY) || (r_mode[r_ptr] == MODE_RUNNING);
        o_sts.walk_end    = (ptr_link == r_head) || (r_cnt == CW'(MAX_TASKS - 1));
    end

    // Result fields, valid while the controller strobes the result.
    assign o_running_slot = 4'(r_cur);
    assign o_running_id   = r_ident[r_cur];
    assign o_switched     = (r_cur != r_before);
    assign o_new_id       = r_new_id;
    assign o_status       = r_status;

    // Sequenced updates of the slot table and scheduler state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                r_used[k]  <= (k == 0);
                r_mode[k]  <= (k == 0) ? MODE_RUNNING : MODE_READY;
                r_ident[k] <= '0;
                r_quant[k] <= (k == 0) ? QUANTUM_BITS'(1) : '0;
                r_ticks[k] <= (k == 0) ? QUANTUM_BITS'(1) : '0;
                r_link[k]  <= '0;
            end
            r_cur     <= '0;
            r_head    <= '0;
            r_next_id <= 32'd1;
            r_depth   <= 8'd0;
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_cmd    <= t_cmd'(i_command);
                    r_q      <= QUANTUM_BITS'(i_quantum);
                    r_ts     <= i_task_slot;
                    r_before <= r_cur;
                    r_new_id <= '0;
                    r_status <= STATUS_OK;
                end
                OP_EXEC: begin
                    case (r_cmd)
                        CMD_TICK:  r_ticks[r_cur] <= tick_new;
                        CMD_SPAWN: r_ptr <= SW'(1);
                        CMD_YIELD: r_ticks[r_cur] <= '0;
                        CMD_BLOCK: begin
                            if (r_cur == IDLE_SLOT) r_status <= STATUS_IGNORED;
                            else r_mode[r_cur] <= MODE_BLOCKED;
                        end
                        CMD_WAKE: begin
                            if (o_sts.wake_ok) begin
                                r_mode[ts_idx] <= MODE_READY;
                                r_nxt          <= ts_idx;
                            end else begin
                                r_status <= STATUS_IGNORED;
                            end
                        end
                        CMD_EXIT: begin
                            if (r_cur == IDLE_SLOT) begin
                                r_status <= STATUS_IGNORED;
                            end else begin
                                r_mode[r_cur] <= MODE_DEAD;
                                r_ptr         <= r_head;
                                r_cnt         <= '0;
                            end
                        end
                        CMD_PREEMPT_OFF: begin
                            if (r_depth != 8'hFF) r_depth <= r_depth + 8'd1;
                        end
                        default: begin
                            if (r_depth != 8'd0) r_depth <= r_depth - 8'd1;
                        end
                    endcase
                end
                // Search for the lowest free slot, one slot a cycle.
                OP_FREE: begin
                    if (!r_used[r_ptr]) begin
                        r_used[r_ptr]  <= 1'b1;
                        r_mode[r_ptr]  <= MODE_READY;
                        r_ident[r_ptr] <= r_next_id;
                        r_new_id       <= r_next_id;
                        r_next_id      <= r_next_id + 32'd1;
                        r_quant[r_ptr] <= r_q;
                        r_ticks[r_ptr] <= r_q;
                        r_link[r_ptr]  <= head_link;
                        r_link[r_head] <= r_ptr;
                    end else if (r_ptr == LAST_SLOT) begin
                        r_status <= STATUS_NO_SLOT;
                    end else begin
                        r_ptr <= r_ptr + SW'(1);
                    end
                end
                // Find the predecessor of the exiting slot and splice it out.
                OP_UNLINK: begin
                    if (o_sts.unlink_done) begin
                        if ((ptr_link == r_cur) && (cur_link != r_cur)) begin
                            r_link[r_ptr] <= cur_link;
                            r_link[r_cur] <= '0;
                            if (r_head == r_cur) r_head <= r_ptr;
                        end
                        r_used[r_cur] <= 1'b0;
                    end else begin
                        r_ptr <= ptr_link;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                OP_CHINIT: begin
                    r_ptr <= head_link;
                    r_cnt <= '0;
                end
                // Walk the ring for the first runnable slot.
                OP_CHWALK: begin
                    if (o_sts.walk_hit) begin
                        r_nxt <= r_ptr;
                    end else if (o_sts.walk_end) begin
                        r_nxt <= IDLE_SLOT;
                    end else begin
                        r_ptr <= ptr_link;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                OP_SWITCH: begin
                    if (r_nxt != r_cur) begin
                        if (r_mode[r_cur] == MODE_RUNNING) r_mode[r_cur] <= MODE_READY;
                        r_mode[r_nxt]  <= MODE_RUNNING;
                        r_ticks[r_nxt] <= r_quant[r_nxt];
                        r_head         <= r_nxt;
                        r_cur          <= r_nxt;
                    end
                end
                default: begin
                    r_cur <= r_cur;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the round-robin task scheduler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import rrts_pkg::*;

    localparam int NSLOT = 16;

    typedef struct {
        t_cmd        cmd;
        logic [15:0] quantum;
        logic [3:0]  slot;
    } t_item;

    typedef struct {
        logic [3:0]  running_slot;
        logic [31:0] running_id;
        logic        switched;
        logic [31:0] new_id;
        logic [1:0]  status;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = '0;
    logic [15:0] i_quantum = '0;
    logic [3:0]  i_task_slot = '0;
    logic        o_valid;
    logic [3:0]  o_running_slot;
    logic [31:0] o_running_id;
    logic        o_switched;
    logic [31:0] o_new_id;
    logic [1:0]  o_status;

    round_robin_task_scheduler_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_quantum(i_quantum), .i_task_slot(i_task_slot),
        .o_valid(o_valid), .o_running_slot(o_running_slot),
        .o_running_id(o_running_id), .o_switched(o_switched),
        .o_new_id(o_new_id), .o_status(o_status)
    );

    always #4 i_clk = ~i_clk;

    // Scheduler state mirrored by the predictor.
    logic        used_q [NSLOT];
    t_mode       mode_q [NSLOT];
    logic [31:0] ident_q [NSLOT];
    logic [15:0] slice_q [NSLOT];
    logic [15:0] left_q [NSLOT];
    logic [3:0]  link_q [NSLOT];
    logic [3:0]  cur_q, head_q;
    logic [31:0] next_ident_q;
    logic [7:0]  depth_q;

    t_item    pending_items[$];
    t_outcome expected_outcomes[$];
    int       mismatches = 0;
    int       sender_idle_pct = 7;
    bit       hold_sender = 0;

    function automatic void sched_reset();
        for (int i = 0; i < NSLOT; i++) begin
            used_q[i] = 0; mode_q[i] = MODE_READY; ident_q[i] = '0;
            slice_q[i] = '0; left_q[i] = '0; link_q[i] = '0;
        end
        used_q[0] = 1; mode_q[0] = MODE_RUNNING; slice_q[0] = 1; left_q[0] = 1;
        cur_q = '0; head_q = '0; next_ident_q = 1; depth_q = '0;
    endfunction

    // First Ready or Running slot after the head, else the idle task.
    function automatic logic [3:0] runnable_after_head();
        logic [3:0] s;
        s = link_q[head_q];
        for (int n = 0; n < NSLOT; n++) begin
            if (mode_q[s] == MODE_READY || mode_q[s] == MODE_RUNNING) return s;
            s = link_q[s];
            if (s == head_q) break;
        end
        return '0;
    endfunction

    function automatic void switch_task(logic [3:0] nxt);
        if (nxt == cur_q) return;
        if (mode_q[cur_q] == MODE_RUNNING) mode_q[cur_q] = MODE_READY;
        mode_q[nxt] = MODE_RUNNING;
        left_q[nxt] = slice_q[nxt];
        head_q = nxt;
        cur_q = nxt;
    endfunction

    function automatic void drop_from_ring(logic [3:0] victim);
        logic [3:0] prev;
        prev = head_q;
        for (int n = 0; n < NSLOT; n++) begin
            if (link_q[prev] == victim || link_q[prev] == head_q) break;
            prev = link_q[prev];
        end
        if (link_q[prev] != victim || link_q[victim] == victim) return;
        link_q[prev] = link_q[victim];
        if (head_q == victim) head_q = prev;
        link_q[victim] = '0;
    endfunction

    function automatic t_outcome schedule_command(t_item it);
        t_outcome r;
        logic [3:0] was;
        int fs;
        was = cur_q;
        r.new_id = '0;
        r.status = STATUS_OK;
        case (it.cmd)
            CMD_TICK: begin
                if (left_q[cur_q] > 0) left_q[cur_q]--;
                if (left_q[cur_q] == 0 && depth_q == 0) switch_task(runnable_after_head());
            end
            CMD_SPAWN: begin
                fs = 1;
                while (fs < NSLOT && used_q[fs]) fs++;
                if (fs >= NSLOT) begin
                    r.status = STATUS_NO_SLOT;
                end else begin
                    used_q[fs] = 1; mode_q[fs] = MODE_READY;
                    ident_q[fs] = next_ident_q; r.new_id = next_ident_q;
                    next_ident_q++;
                    slice_q[fs] = it.quantum; left_q[fs] = it.quantum;
                    link_q[fs] = link_q[head_q];
                    link_q[head_q] = fs[3:0];
                end
            end
            CMD_YIELD: begin
                left_q[cur_q] = '0;
                switch_task(runnable_after_head());
            end
            CMD_BLOCK: begin
                if (cur_q == 0) r.status = STATUS_IGNORED;
                else begin
                    mode_q[cur_q] = MODE_BLOCKED;
                    switch_task(runnable_after_head());
                end
            end
            CMD_WAKE: begin
                if (!used_q[it.slot] || mode_q[it.slot] != MODE_BLOCKED) begin
                    r.status = STATUS_IGNORED;
                end else begin
                    mode_q[it.slot] = MODE_READY;
                    if (cur_q == 0) switch_task(it.slot);
                end
            end
            CMD_EXIT: begin
                if (cur_q == 0) r.status = STATUS_IGNORED;
                else begin
                    mode_q[cur_q] = MODE_DEAD;
                    drop_from_ring(cur_q);
                    used_q[was] = 0;
                    switch_task(runnable_after_head());
                end
            end
            CMD_PREEMPT_OFF: if (depth_q != 8'd255) depth_q++;
            default:         if (depth_q != 0) depth_q--;
        endcase
        r.running_slot = cur_q;
        r.running_id = ident_q[cur_q];
        r.switched = (cur_q != was);
        return r;
    endfunction

    function automatic void queue_item(t_cmd c, logic [15:0] q, logic [3:0] s);
        t_item it;
        it.cmd = c; it.quantum = q; it.slot = s;
        pending_items.push_back(it);
    endfunction

    // Random command, weighted so tasks get spawned, blocked and woken often.
    function automatic void queue_random();
        int sel;
        logic [15:0] q;
        sel = $urandom_range(0, 99);
        q = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if (sel < 30)      queue_item(CMD_TICK, 16'($urandom), 4'($urandom));
        else if (sel < 48) queue_item(CMD_SPAWN, q, 4'($urandom));
        else if (sel < 58) queue_item(CMD_YIELD, 16'($urandom), 4'($urandom));
        else if (sel < 68) queue_item(CMD_BLOCK, 16'($urandom), 4'($urandom));
        else if (sel < 84) queue_item(CMD_WAKE, 16'($urandom), 4'($urandom));
        else if (sel < 92) queue_item(CMD_EXIT, 16'($urandom), 4'($urandom));
        else if (sel < 96) queue_item(CMD_PREEMPT_OFF, 16'($urandom), 4'($urandom));
        else               queue_item(CMD_PREEMPT_ON, 16'($urandom), 4'($urandom));
    endfunction

    // Driver: one transfer per accepted start, prediction made at acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_outcomes.push_back(schedule_command(pending_items.pop_front()));
            end
            if (!start || !busy) begin
                if (pending_items.size() != 0 && !hold_sender
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                    start       <= 1'b1;
                    i_command   <= pending_items[0].cmd;
                    i_quantum   <= pending_items[0].quantum;
                    i_task_slot <= pending_items[0].slot;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result slot=%0d", o_running_slot);
            end else begin
                e = expected_outcomes.pop_front();
                if (o_running_slot !== e.running_slot || o_running_id !== e.running_id
                    || o_switched !== e.switched || o_new_id !== e.new_id
                    || o_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp slot=%0d id=%0h sw=%0b new=%0h st=%0d",
                            e.running_slot, e.running_id, e.switched, e.new_id, e.status);
                        $display("         act slot=%0d id=%0h sw=%0b new=%0h st=%0d",
                            o_running_slot, o_running_id, o_switched, o_new_id, o_status);
                    end
                end
            end
        end
    end

    task automatic drain_all();
        while (pending_items.size() != 0 || start || expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        sched_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle-only cases, extremes, fill the table, wake paths.
        queue_item(CMD_TICK, 16'hFFFF, 4'hF);
        queue_item(CMD_BLOCK, 16'h0, 4'h0);
        queue_item(CMD_EXIT, 16'h0, 4'h0);
        queue_item(CMD_WAKE, 16'h0, 4'h0);
        queue_item(CMD_PREEMPT_ON, 16'h0, 4'h0);
        queue_item(CMD_SPAWN, 16'h0, 4'h0);
        queue_item(CMD_SPAWN, 16'hFFFF, 4'hF);
        for (int i = 0; i < 14; i++) queue_item(CMD_SPAWN, 16'(i), 4'h0);
        queue_item(CMD_TICK, 16'h0, 4'h0);
        queue_item(CMD_BLOCK, 16'h0, 4'h0);
        queue_item(CMD_WAKE, 16'h0, 4'hF);
        queue_item(CMD_YIELD, 16'h0, 4'h0);
        queue_item(CMD_EXIT, 16'h0, 4'h0);
        drain_all();

        // Preempt depth saturation and release.
        for (int i = 0; i < 260; i++) queue_item(CMD_PREEMPT_OFF, 16'($urandom), 4'($urandom));
        queue_item(CMD_TICK, 16'h0, 4'h0);
        for (int i = 0; i < 258; i++) queue_item(CMD_PREEMPT_ON, 16'($urandom), 4'($urandom));
        drain_all();

        // Random phases: sender idling seldom, then often, then never.
        sender_idle_pct = 7;
        for (int i = 0; i < 120; i++) queue_random();
        drain_all();
        hold_sender = 1;
        repeat (20) @(posedge i_clk);
        hold_sender = 0;
        sender_idle_pct = 71;
        for (int i = 0; i < 120; i++) queue_random();
        drain_all();
        sender_idle_pct = 0;
        for (int i = 0; i < 160; i++) queue_random();
        drain_all();
        repeat (50) @(posedge i_clk);

        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
